[rtl/kli_pkg.sv]
// ----------------------------------------------------------------------------
// Keyframe linear interpolator package
// Shared constants, command and key types for the interpolator modules.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int MAX_KEYS    = 16;
    localparam int KEY_IDX_W   = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W       = $clog2(MAX_KEYS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;
    localparam int PROD_W    = 51;
    localparam int DIV_STEP_W = $clog2(FRAC_BITS + 1);

    localparam int KEY_COUNT_W            = 5;
    localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = KEY_COUNT_W'(2);
    localparam int IN_DATA_W              = 168;
    localparam int OUT_DATA_W             = 96;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_START,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        logic [31:0] key_time;
        logic [31:0] key_x;
        logic [31:0] key_y;
        logic [31:0] key_z;
    } key_entry_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  key_slot;
        key_entry_t  key;
        logic [31:0] now_time;
    } cmd_t;

endpackage

[rtl/kli_front.sv]
// ----------------------------------------------------------------------------
// Keyframe interpolator front end
// Accepts input transactions, decodes the opcode and queues commands.
// ----------------------------------------------------------------------------
module kli_front (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kli_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,
    input  logic                            queue_full,
    output logic                            queue_push,
    output kli_pkg::cmd_t                   queue_cmd
);

    logic keep;

    always_comb
    begin
        queue_cmd.kind         = kli_pkg::CMD_LOAD;
        queue_cmd.key_slot     = s_axis_tdata[3:0];
        queue_cmd.key.key_time = s_axis_tdata[35:4];
        queue_cmd.key.key_x    = s_axis_tdata[67:36];
        queue_cmd.key.key_y    = s_axis_tdata[99:68];
        queue_cmd.key.key_z    = s_axis_tdata[131:100];
        queue_cmd.now_time     = s_axis_tdata[163:132];
        keep                   = 1'b1;
        unique case (s_axis_tuser)
            kli_pkg::OP_LOAD:  queue_cmd.kind = kli_pkg::CMD_LOAD;
            kli_pkg::OP_START: queue_cmd.kind = kli_pkg::CMD_START;
            kli_pkg::OP_TICK:  queue_cmd.kind = kli_pkg::CMD_TICK;
            default:           keep = 1'b0;
        endcase
    end

    assign s_axis_tready = !queue_full;
    assign queue_push    = s_axis_tvalid && !queue_full && keep;

endmodule

[rtl/kli_fifo.sv]
// ----------------------------------------------------------------------------
// Keyframe interpolator command queue
// Short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
module kli_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kli_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output kli_pkg::cmd_t head
);

    kli_pkg::cmd_t                  slot_reg [kli_pkg::QUEUE_DEPTH];
    logic [kli_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [kli_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [kli_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full  = (count_reg == kli_pkg::QCNT_W'(kli_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == kli_pkg::QPTR_W'(kli_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == kli_pkg::QPTR_W'(kli_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/kli_div.sv]
// ----------------------------------------------------------------------------
// Keyframe interpolator fraction divider
// Restoring divider giving floor(num * 2^16 / span) for num below span.
// ----------------------------------------------------------------------------
module kli_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [31:0]                     num,
    input  logic [31:0]                     span,
    output logic                            done,
    output logic [kli_pkg::FRAC_BITS-1:0]   quot
);

    logic [31:0]                        rem_reg, rem_next;
    logic [31:0]                        span_reg, span_next;
    logic [kli_pkg::FRAC_BITS-1:0]      quot_reg, quot_next;
    logic [kli_pkg::DIV_STEP_W-1:0]     step_reg, step_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [32:0]                        shifted;
    logic [32:0]                        trial;

    always_comb
    begin
        rem_next  = rem_reg;
        span_next = span_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, span_reg};
        if (start)
        begin
            rem_next  = num;
            span_next = span;
            quot_next = '0;
            step_next = kli_pkg::DIV_STEP_W'(kli_pkg::FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next  = trial[31:0];
                quot_next = {quot_reg[kli_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[31:0];
                quot_next = {quot_reg[kli_pkg::FRAC_BITS-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == kli_pkg::DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        span_reg <= span_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/kli_engine.sv]
// ----------------------------------------------------------------------------
// Keyframe interpolator engine
// Holds the key table, walks segments on a tick and mixes the keypoints.
// ----------------------------------------------------------------------------
module kli_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [kli_pkg::KEY_COUNT_W-1:0]     cfg_wr_data,
    input  logic                                cmd_valid,
    input  kli_pkg::cmd_t                       cmd_head,
    output logic                                cmd_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [kli_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [0:0]                          m_axis_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_SPAN,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_EMIT
    } state_t;

    state_t                             state_reg, state_next;
    logic [kli_pkg::CNT_W-1:0]          seg_reg, seg_next;
    logic [31:0]                        elapsed_reg, elapsed_next;
    logic [31:0]                        start_stamp_reg, start_stamp_next;
    logic                               running_reg, running_next;
    logic [kli_pkg::KEY_COUNT_W-1:0]    key_count_reg, key_count_next;
    kli_pkg::key_entry_t                b_reg, b_next;
    kli_pkg::key_entry_t                a_reg, a_next;
    logic signed [32:0]                 diff_reg [3];
    logic signed [32:0]                 diff_next [3];
    logic [kli_pkg::FRAC_W-1:0]         f_reg, f_next;
    logic signed [kli_pkg::PROD_W-1:0]  prod_reg [3];
    logic signed [kli_pkg::PROD_W-1:0]  prod_next [3];
    logic [31:0]                        res_reg [3];
    logic [31:0]                        res_next [3];
    logic                               res_fin_reg, res_fin_next;
    logic                               out_valid_reg, out_valid_next;
    logic [kli_pkg::OUT_DATA_W-1:0]     out_data_reg, out_data_next;
    logic                               out_fin_reg, out_fin_next;

    kli_pkg::key_entry_t                key_mem [kli_pkg::MAX_KEYS];
    kli_pkg::key_entry_t                rd_data_reg;
    logic [kli_pkg::KEY_IDX_W-1:0]      rd_addr;
    logic                               mem_we;
    logic [kli_pkg::KEY_IDX_W-1:0]      mem_waddr;

    logic [kli_pkg::CNT_W-1:0]          key_lim;
    logic [kli_pkg::CNT_W-1:0]          seg_inc;
    logic                               div_start;
    logic [31:0]                        div_num;
    logic [31:0]                        div_span;
    logic                               div_done;
    logic [kli_pkg::FRAC_BITS-1:0]      div_quot;

    logic [31:0]                        a_comp [3];
    logic [31:0]                        b_comp [3];

    kli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .span  (div_span),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (key_count_reg < kli_pkg::KEY_COUNT_W'(2))
        begin
            key_lim = kli_pkg::CNT_W'(2);
        end
        else if (32'(key_count_reg) > kli_pkg::MAX_KEYS)
        begin
            key_lim = kli_pkg::CNT_W'(kli_pkg::MAX_KEYS);
        end
        else
        begin
            key_lim = kli_pkg::CNT_W'(key_count_reg);
        end
    end

    assign seg_inc   = seg_reg + 1'b1;
    assign mem_waddr = kli_pkg::KEY_IDX_W'(cmd_head.key_slot);

    assign a_comp[0] = rd_data_reg.key_x;
    assign a_comp[1] = rd_data_reg.key_y;
    assign a_comp[2] = rd_data_reg.key_z;
    assign b_comp[0] = b_reg.key_x;
    assign b_comp[1] = b_reg.key_y;
    assign b_comp[2] = b_reg.key_z;

    always_comb
    begin
        logic [31:0]                        t0;
        logic [31:0]                        t1;
        logic [31:0]                        span;
        logic [31:0]                        num;
        logic signed [kli_pkg::PROD_W-1:0]  sum;
        logic [31:0]                        a_word;

        state_next       = state_reg;
        seg_next         = seg_reg;
        elapsed_next     = elapsed_reg;
        start_stamp_next = start_stamp_reg;
        running_next     = running_reg;
        key_count_next   = key_count_reg;
        b_next           = b_reg;
        a_next           = a_reg;
        diff_next        = diff_reg;
        f_next           = f_reg;
        prod_next        = prod_reg;
        res_next         = res_reg;
        res_fin_next     = res_fin_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_fin_next     = out_fin_reg;
        cmd_pop          = 1'b0;
        mem_we           = 1'b0;
        rd_addr          = seg_reg[kli_pkg::KEY_IDX_W-1:0];
        div_start        = 1'b0;
        t0               = rd_data_reg.key_time;
        t1               = b_reg.key_time;
        span             = t1 - t0;
        num              = (elapsed_reg > t0) ? (elapsed_reg - t0) : 32'd0;
        div_num          = num;
        div_span         = span;
        sum              = '0;
        a_word           = '0;

        if (cfg_wr_en)
        begin
            key_count_next = cfg_wr_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_head.kind)
                        kli_pkg::CMD_LOAD:
                        begin
                            mem_we = (32'(cmd_head.key_slot) < kli_pkg::MAX_KEYS);
                        end
                        kli_pkg::CMD_START:
                        begin
                            start_stamp_next = cmd_head.now_time;
                            seg_next         = '0;
                            running_next     = 1'b1;
                        end
                        kli_pkg::CMD_TICK:
                        begin
                            if (running_reg)
                            begin
                                elapsed_next = cmd_head.now_time - start_stamp_reg;
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (seg_inc < key_lim)
                begin
                    rd_addr    = seg_inc[kli_pkg::KEY_IDX_W-1:0];
                    state_next = ST_CHECK;
                end
                else
                begin
                    running_next = 1'b0;
                    res_fin_next = 1'b1;
                    for (int c = 0; c < 3; c++)
                    begin
                        res_next[c] = '0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_CHECK:
            begin
                if (rd_data_reg.key_time < elapsed_reg)
                begin
                    seg_next   = seg_inc;
                    state_next = ST_WALK;
                end
                else
                begin
                    b_next     = rd_data_reg;
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                a_next = rd_data_reg;
                for (int c = 0; c < 3; c++)
                begin
                    diff_next[c] = $signed({b_comp[c][31], b_comp[c]})
                                 - $signed({a_comp[c][31], a_comp[c]});
                end
                if (t1 > t0)
                begin
                    if (num >= span)
                    begin
                        f_next     = kli_pkg::FRAC_ONE;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    f_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    f_next     = {1'b0, div_quot};
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_next[c] = diff_reg[c] * $signed({1'b0, f_reg});
                end
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    unique case (c)
                        0:       a_word = a_reg.key_x;
                        1:       a_word = a_reg.key_y;
                        default: a_word = a_reg.key_z;
                    endcase
                    sum = $signed({{(kli_pkg::PROD_W - 32){a_word[31]}}, a_word})
                        + (prod_reg[c] >>> kli_pkg::FRAC_BITS);
                    res_next[c] = sum[31:0];
                end
                res_fin_next = 1'b0;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_reg[2], res_reg[1], res_reg[0]};
                    out_fin_next   = res_fin_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seg_reg         <= '0;
            start_stamp_reg <= '0;
            running_reg     <= 1'b0;
            key_count_reg   <= kli_pkg::KEY_COUNT_RESET;
            out_valid_reg   <= 1'b0;
            f_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            seg_reg         <= seg_next;
            start_stamp_reg <= start_stamp_next;
            running_reg     <= running_next;
            key_count_reg   <= key_count_next;
            out_valid_reg   <= out_valid_next;
            f_reg           <= f_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        b_reg        <= b_next;
        a_reg        <= a_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        res_fin_reg  <= res_fin_next;
        out_data_reg <= out_data_next;
        out_fin_reg  <= out_fin_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= cmd_head.key;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_fin_reg;

    a_seg_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        32'(seg_reg) < kli_pkg::MAX_KEYS)
        else $error("segment index beyond the key table");

    a_frac_limit: assert property (@(posedge clk) disable iff (!rst_n)
        f_reg <= kli_pkg::FRAC_ONE)
        else $error("completion factor above one");

    a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && res_fin_reg) |-> !running_reg)
        else $error("finished result while the channel still runs");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider completed outside the division wait");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command taken from an empty queue");

endmodule

[rtl/keyframe_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// One channel of a piecewise-linear keyframe animator with xyz keypoints.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// input     s_axis_tvalid/tready         tdata fields, tuser opcode
// output    m_axis_tvalid/tready         tdata value xyz, tuser finished
// config    cfg_wr_en                    cfg_wr_data key_count
//
// A load or start transaction is completed as the engine takes it from the queue.
// A tick walks the segments over the single read port of the key table and, where
// needed, runs the 16-step fraction divider. Reset clears the control state; the
// key table holds nothing defined until loaded. Input stalls only when the
// two-entry queue is full; a waiting result holds the engine in its emit step
// until the output register frees.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [kli_pkg::KEY_COUNT_W-1:0]     cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key_slot, key_time, key_x, key_y, key_z, now_time, zero padding
    input  logic [kli_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // opcode
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // value_x, value_y, value_z
    output logic [kli_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // finished
    output logic [0:0]                          m_axis_tuser
);

    logic           queue_full;
    logic           queue_push;
    kli_pkg::cmd_t  queue_cmd;
    logic           queue_pop;
    logic           queue_valid;
    kli_pkg::cmd_t  queue_head;

    kli_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .queue_push    (queue_push),
        .queue_cmd     (queue_cmd)
    );

    kli_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (queue_push),
        .push_cmd (queue_cmd),
        .full     (queue_full),
        .pop      (queue_pop),
        .valid    (queue_valid),
        .head     (queue_head)
    );

    kli_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd_valid     (queue_valid),
        .cmd_head      (queue_head),
        .cmd_pop       (queue_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
